/* src/assert_macros.svh */
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define KIDP_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define KIDP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/kidp_pkg.sv */
package kidp_pkg;

  localparam int NUM_PROCESSORS = 64;
  localparam int NUM_VECTORS    = 10;
  localparam int ENTRY_COUNT    = NUM_PROCESSORS * NUM_VECTORS;
  localparam int ADDR_W         = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;

  localparam int CPU_W  = 6;
  localparam int VEC_W  = 4;
  localparam int DATA_W = 64;

  localparam logic FUNC_ENTER = 1'b0;
  localparam logic FUNC_EXIT  = 1'b1;

  // base holds (total - start time) while the entry is active
  typedef struct packed {
    logic              active;
    logic [DATA_W-1:0] base;
    logic [DATA_W-1:0] observed;
    logic [DATA_W-1:0] unresolved;
    logic [DATA_W-1:0] total;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE
  } kidp_state_t;

  typedef struct packed {
    logic clr;
    logic capture;
    logic commit;
  } kidp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic keep;
    logic out_stall;
  } kidp_stat_t;

  function automatic logic in_range(logic [CPU_W-1:0] cpu, logic [VEC_W-1:0] vec);
    return (32'(cpu) < NUM_PROCESSORS) && (32'(vec) < NUM_VECTORS);
  endfunction

  function automatic logic [ADDR_W-1:0] entry_addr(logic [CPU_W-1:0] cpu,
                                                   logic [VEC_W-1:0] vec);
    logic [ADDR_W-1:0] prod;
    prod = ADDR_W'(cpu) * ADDR_W'(NUM_VECTORS);
    return prod + ADDR_W'(vec);
  endfunction

endpackage

/* src/keyed_interval_duration_profiler_unit.sv */
// Results: an in-range event is read from the entry store on accept; its
// result beat is registered when the read-modify-write commits, which waits
// while the output is stalled. Out-of-range events give no beat. A new event
// is not taken until the update is done. Reset: synchronous, active low; a
// clear sweep then zeroes all 640 entries, one a cycle, with in_ready low throughout.
`include "assert_macros.svh"

module keyed_interval_duration_profiler_unit
  import kidp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_func,
  input  logic [CPU_W-1:0]  in_cpu_index,
  input  logic [VEC_W-1:0]  in_vector,
  input  logic [DATA_W-1:0] in_timestamp,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CPU_W-1:0]  out_cpu,
  output logic [VEC_W-1:0]  out_vector,
  output logic [DATA_W-1:0] out_observed_count,
  output logic [DATA_W-1:0] out_unresolved_count,
  output logic [DATA_W-1:0] out_total_time,
  output logic              out_entry_active
);

  kidp_cmd_t  cmd;
  kidp_stat_t stat;

  kidp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  kidp_dpath u_dpath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .stat                 (stat),
    .in_func              (in_func),
    .in_cpu_index         (in_cpu_index),
    .in_vector            (in_vector),
    .in_timestamp         (in_timestamp),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_cpu              (out_cpu),
    .out_vector           (out_vector),
    .out_observed_count   (out_observed_count),
    .out_unresolved_count (out_unresolved_count),
    .out_total_time       (out_total_time),
    .out_entry_active     (out_entry_active)
  );

  `KIDP_ASSERT_NEXT(a_accept_then_busy, in_valid && in_ready, !in_ready, "no update")
  `KIDP_ASSERT_IMPL(a_rose_after_commit, $rose(out_valid), $past(cmd.commit), "no commit")
  `KIDP_ASSERT_IMPL(a_no_rw_clash, cmd.capture, !(cmd.clr || cmd.commit), "store clash")

endmodule

/* src/kidp_ram.sv */
module kidp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/kidp_ctrl.sv */
module kidp_ctrl
  import kidp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  kidp_stat_t stat,
  output kidp_cmd_t  cmd
);

  kidp_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (stat.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (!stat.keep || !stat.out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
      end
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_UPDATE: begin
        cmd.commit = stat.keep && !stat.out_stall;
      end
      default: ;
    endcase
  end

endmodule

/* src/kidp_dpath.sv */
module kidp_dpath
  import kidp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  kidp_cmd_t         cmd,
  output kidp_stat_t        stat,
  input  logic              in_func,
  input  logic [CPU_W-1:0]  in_cpu_index,
  input  logic [VEC_W-1:0]  in_vector,
  input  logic [DATA_W-1:0] in_timestamp,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CPU_W-1:0]  out_cpu,
  output logic [VEC_W-1:0]  out_vector,
  output logic [DATA_W-1:0] out_observed_count,
  output logic [DATA_W-1:0] out_unresolved_count,
  output logic [DATA_W-1:0] out_total_time,
  output logic              out_entry_active
);

  logic [ADDR_W-1:0] clr_cnt_r;
  logic              keep_r;
  logic              func_r;
  logic [CPU_W-1:0]  cpu_r;
  logic [VEC_W-1:0]  vec_r;
  logic [DATA_W-1:0] ts_r;
  logic [ADDR_W-1:0] addr_r;
  logic              out_valid_r;
  logic [CPU_W-1:0]  out_cpu_r;
  logic [VEC_W-1:0]  out_vec_r;
  entry_t            out_ent_r;

  entry_t            cur, upd;
  logic [ENTRY_W-1:0] rdata, wdata;
  logic [ADDR_W-1:0] waddr;
  logic              we;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      keep_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (cmd.capture) keep_r <= in_range(in_cpu_index, in_vector);
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= in_func;
      cpu_r  <= in_cpu_index;
      vec_r  <= in_vector;
      ts_r   <= in_timestamp;
      addr_r <= entry_addr(in_cpu_index, in_vector);
    end
    if (cmd.commit) begin
      out_cpu_r <= cpu_r;
      out_vec_r <= vec_r;
      out_ent_r <= upd;
    end
  end

  // read-modify-write of one entry
  always_comb begin
    cur = entry_t'(rdata);
    upd = cur;
    if (func_r ^ cur.active) upd.unresolved = cur.unresolved + 1'b1;
    if (func_r == FUNC_ENTER) begin
      upd.base   = cur.total - ts_r;
      upd.active = 1'b1;
    end else if (cur.active) begin
      upd.observed = cur.observed + 1'b1;
      upd.total    = cur.base + ts_r;
      upd.active   = 1'b0;
    end
  end

  assign we    = cmd.clr || cmd.commit;
  assign waddr = cmd.clr ? clr_cnt_r : addr_r;
  assign wdata = cmd.clr ? '0 : ENTRY_W'(upd);

  kidp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRY_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.capture),
    .raddr (entry_addr(in_cpu_index, in_vector)),
    .rdata (rdata)
  );

  assign stat.clr_last  = (clr_cnt_r == ADDR_W'(ENTRY_COUNT - 1));
  assign stat.keep      = keep_r;
  assign stat.out_stall = out_valid_r && !out_ready;

  assign out_valid            = out_valid_r;
  assign out_cpu              = out_cpu_r;
  assign out_vector           = out_vec_r;
  assign out_observed_count   = out_ent_r.observed;
  assign out_unresolved_count = out_ent_r.unresolved;
  assign out_total_time       = out_ent_r.total;
  assign out_entry_active     = out_ent_r.active;

endmodule

/* verif/keyed_interval_duration_profiler_unit_tb.sv */
`timescale 1ns / 100ps

module keyed_interval_duration_profiler_unit_tb;
  import kidp_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 300;

  typedef struct {
    logic [CPU_W-1:0]  cpu;
    logic [VEC_W-1:0]  vec;
    logic [DATA_W-1:0] observed;
    logic [DATA_W-1:0] unresolved;
    logic [DATA_W-1:0] total;
    logic              active;
  } profile_rec_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic              in_func;
  logic [CPU_W-1:0]  in_cpu_index;
  logic [VEC_W-1:0]  in_vector;
  logic [DATA_W-1:0] in_timestamp;
  logic              out_valid;
  logic              out_ready;
  logic [CPU_W-1:0]  out_cpu;
  logic [VEC_W-1:0]  out_vector;
  logic [DATA_W-1:0] out_observed_count;
  logic [DATA_W-1:0] out_unresolved_count;
  logic [DATA_W-1:0] out_total_time;
  logic              out_entry_active;

  // per-entry shadow of the profiler state
  logic              open_mark    [ENTRY_COUNT];
  logic [DATA_W-1:0] open_since   [ENTRY_COUNT];
  logic [DATA_W-1:0] pair_tally   [ENTRY_COUNT];
  logic [DATA_W-1:0] orphan_tally [ENTRY_COUNT];
  logic [DATA_W-1:0] busy_ns      [ENTRY_COUNT];

  profile_rec_t profile_q[$];

  int in_idle_pct;
  int out_stall_pct;
  int err_count;
  int stall_cycles;
  int hold_left;
  bit hold_req;

  keyed_interval_duration_profiler_unit u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_func              (in_func),
    .in_cpu_index         (in_cpu_index),
    .in_vector            (in_vector),
    .in_timestamp         (in_timestamp),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_cpu              (out_cpu),
    .out_vector           (out_vector),
    .out_observed_count   (out_observed_count),
    .out_unresolved_count (out_unresolved_count),
    .out_total_time       (out_total_time),
    .out_entry_active     (out_entry_active)
  );

  always #5 clk = ~clk;

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else begin
      out_ready = ($urandom_range(99) >= out_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic note_mismatch(input string fld, input logic [DATA_W-1:0] exp_v,
                               input logic [DATA_W-1:0] act_v);
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, fld, exp_v, act_v);
    err_count++;
  endtask

  always @(posedge clk) begin
    profile_rec_t want;
    if (rst_n && out_valid && out_ready) begin
      if (profile_q.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got cpu %0d vector %0d",
                 $time, out_cpu, out_vector);
        err_count++;
      end else begin
        want = profile_q.pop_front();
        if (out_cpu !== want.cpu)
          note_mismatch("out_cpu", DATA_W'(want.cpu), DATA_W'(out_cpu));
        if (out_vector !== want.vec)
          note_mismatch("out_vector", DATA_W'(want.vec), DATA_W'(out_vector));
        if (out_observed_count !== want.observed)
          note_mismatch("out_observed_count", want.observed, out_observed_count);
        if (out_unresolved_count !== want.unresolved)
          note_mismatch("out_unresolved_count", want.unresolved, out_unresolved_count);
        if (out_total_time !== want.total)
          note_mismatch("out_total_time", want.total, out_total_time);
        if (out_entry_active !== want.active)
          note_mismatch("out_entry_active", DATA_W'(want.active),
                        DATA_W'(out_entry_active));
      end
    end
  end

  // called and returns at a falling edge; valid stays high between back-to-back beats
  task automatic send_event(input logic f, input logic [CPU_W-1:0] c,
                            input logic [VEC_W-1:0] v, input logic [DATA_W-1:0] ts);
    int idx;
    profile_rec_t rec;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    in_func      = f;
    in_cpu_index = c;
    in_vector    = v;
    in_timestamp = ts;
    do @(posedge clk); while (!(in_valid && in_ready));
    if (int'(c) < NUM_PROCESSORS && int'(v) < NUM_VECTORS) begin
      idx = int'(c) * NUM_VECTORS + int'(v);
      if (f == FUNC_ENTER) begin
        if (open_mark[idx])
          orphan_tally[idx] += 1;
        open_since[idx] = ts;
        open_mark[idx]  = 1'b1;
      end else if (!open_mark[idx]) begin
        orphan_tally[idx] += 1;
      end else begin
        pair_tally[idx] += 1;
        busy_ns[idx]    += ts - open_since[idx];
        open_mark[idx]  = 1'b0;
      end
      rec.cpu        = c;
      rec.vec        = v;
      rec.observed   = pair_tally[idx];
      rec.unresolved = orphan_tally[idx];
      rec.total      = busy_ns[idx];
      rec.active     = open_mark[idx];
      profile_q.push_back(rec);
    end
    @(negedge clk);
  endtask

  task automatic test_directed_cases();
    in_idle_pct   = 0;
    out_stall_pct = 0;
    // zero timestamp on enter, then a normal exit, then exit on idle
    send_event(FUNC_ENTER, 6'd0, 4'd0, 64'd0);
    send_event(FUNC_EXIT,  6'd0, 4'd0, 64'd100);
    send_event(FUNC_EXIT,  6'd0, 4'd0, 64'd200);
    // re-enter while open, then exit earlier than start: duration wraps
    send_event(FUNC_ENTER, 6'd63, 4'd9, '1);
    send_event(FUNC_ENTER, 6'd63, 4'd9, 64'd5);
    send_event(FUNC_EXIT,  6'd63, 4'd9, 64'd3);
    // total wraps past 2^64
    send_event(FUNC_ENTER, 6'd63, 4'd9, 64'd0);
    send_event(FUNC_EXIT,  6'd63, 4'd9, 64'd2);
    // out-of-range vectors are dropped
    send_event(FUNC_ENTER, 6'd63, 4'd10, 64'd7);
    send_event(FUNC_EXIT,  6'd0,  4'd15, '1);
    send_event(FUNC_ENTER, 6'd21, 4'd12, 64'h5555_5555_5555_5555);
    // alternating bit patterns
    send_event(FUNC_ENTER, 6'd42, 4'd5, 64'h5555_5555_5555_5555);
    send_event(FUNC_EXIT,  6'd42, 4'd5, 64'hAAAA_AAAA_AAAA_AAAA);
    send_event(FUNC_EXIT,  6'd21, 4'd3, 64'd0);
    // zero-length interval
    send_event(FUNC_ENTER, 6'd0, 4'd0, 64'h8000_0000_0000_0000);
    send_event(FUNC_EXIT,  6'd0, 4'd0, 64'h8000_0000_0000_0000);
    send_event(FUNC_ENTER, 6'd42, 4'd5, '1);
    in_valid = 1'b0;
  endtask

  task automatic test_random_traffic(input int n, input int in_pct, input int out_pct);
    logic [CPU_W-1:0]  hot_cpu [4];
    logic [VEC_W-1:0]  hot_vec [2];
    logic [DATA_W-1:0] clock_ns;
    logic [DATA_W-1:0] ts;
    logic [CPU_W-1:0]  c;
    logic [VEC_W-1:0]  v;
    logic              f;
    int                r;
    in_idle_pct   = in_pct;
    out_stall_pct = out_pct;
    hot_cpu[0] = '0;
    hot_cpu[1] = '1;
    hot_cpu[2] = CPU_W'($urandom_range(63));
    hot_cpu[3] = CPU_W'($urandom_range(63));
    hot_vec[0] = VEC_W'($urandom_range(NUM_VECTORS - 1));
    hot_vec[1] = VEC_W'(NUM_VECTORS - 1);
    clock_ns   = {$urandom, $urandom};
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      c = (r < 70) ? hot_cpu[$urandom_range(3)] : CPU_W'($urandom_range(63));
      r = $urandom_range(99);
      if (r < 10)
        v = VEC_W'($urandom_range(15));
      else if (r < 60)
        v = hot_vec[$urandom_range(1)];
      else
        v = VEC_W'($urandom_range(NUM_VECTORS - 1));
      // mostly well-formed enter/exit pairs, some mismatches
      r = $urandom_range(99);
      if (int'(c) < NUM_PROCESSORS && int'(v) < NUM_VECTORS &&
          open_mark[int'(c) * NUM_VECTORS + int'(v)])
        f = (r < 85) ? FUNC_EXIT : FUNC_ENTER;
      else
        f = (r < 85) ? FUNC_ENTER : FUNC_EXIT;
      clock_ns += DATA_W'($urandom_range(5000, 1));
      r = $urandom_range(99);
      if (r < 5)
        ts = {$urandom, $urandom};
      else if (r < 7)
        ts = '0;
      else
        ts = clock_ns;
      send_event(f, c, v, ts);
    end
    in_valid = 1'b0;
  endtask

  task automatic test_output_hold();
    in_idle_pct   = 0;
    out_stall_pct = 0;
    hold_req      = 1'b1;
    for (int i = 0; i < 40; i++)
      send_event(i[0] ? FUNC_EXIT : FUNC_ENTER, CPU_W'($urandom_range(63)),
                 VEC_W'($urandom_range(NUM_VECTORS - 1)), {$urandom, $urandom});
    in_valid = 1'b0;
  endtask

  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_func       = FUNC_ENTER;
    in_cpu_index  = '0;
    in_vector     = '0;
    in_timestamp  = '0;
    out_ready     = 1'b0;
    in_idle_pct   = 0;
    out_stall_pct = 0;
    err_count     = 0;
    stall_cycles  = 0;
    hold_left     = 0;
    hold_req      = 1'b0;
    for (int i = 0; i < ENTRY_COUNT; i++) begin
      open_mark[i]    = 1'b0;
      open_since[i]   = '0;
      pair_tally[i]   = '0;
      orphan_tally[i] = '0;
      busy_ns[i]      = '0;
    end
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed_cases();
    test_random_traffic(450, 0, 0);
    test_random_traffic(450, 68, 0);
    test_random_traffic(450, 0, 68);
    test_output_hold();
    test_random_traffic(450, 25, 25);

    while (profile_q.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
